// ===== sv/clb_pkg.sv =====
package clb_pkg;

   localparam int RowsDefault     = 32;
   localparam int ColsDefault     = 32;
   localparam int ChannelsDefault = 64;
   localparam int MaxStepsDefault = 9;

   typedef enum logic [1:0] {
      MODE_LOAD_GRAD = 2'd0,
      MODE_LOAD_A    = 2'd1,
      MODE_LOAD_B    = 2'd2,
      MODE_READ      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_STORED    = 2'd0,
      ST_READ_OK   = 2'd1,
      ST_RANGE     = 2'd2,
      ST_BAD_CFG   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_ROWS     = 3'd0,
      CSR_COLS     = 3'd1,
      CSR_CHANNELS = 3'd2,
      CSR_STRIDE   = 3'd3,
      CSR_LIMIT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [4:0]         row;
      logic [4:0]         col;
      logic [5:0]         channel;
      logic [6:0]         disp_index;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [39:0] grad_a_value;
      logic signed [39:0] grad_b_value;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [5:0] rows;
      logic [5:0] cols;
      logic [6:0] channels;
      logic [3:0] stride;
      logic [5:0] limit;
   } cfg_type;

   // Command passed from the front end to the execution engine.
   typedef struct packed {
      req_type    req;
      logic       is_load;
      logic       is_read;
      status_type early_status;
      logic [5:0] steps;
   } cmd_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_ISSUE,
      BE_WAIT,
      BE_DRAIN,
      BE_DIV,
      BE_DONE
   } be_state_type;

endpackage

// ===== sv/clb_front.sv =====
module clb_front
   import clb_pkg::*;
#(
   parameter int ROWS      = RowsDefault,
   parameter int COLS      = ColsDefault,
   parameter int CHANNELS  = ChannelsDefault,
   parameter int MAX_STEPS = MaxStepsDefault
) (
   input  logic    start,
   input  req_type req_data,
   input  cfg_type cfg,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd,
   output logic    busy
);

   localparam int Slots = MAX_STEPS * MAX_STEPS;

   logic       ratio_ok;
   logic [5:0] ratio;
   logic [5:0] steps;
   logic       bad_cfg;
   logic       load_oob;
   logic       read_oob;
   cmd_type    cmd;

   // Find limit/stride with a small compare chain (stride is 1..15, quotient <= 32).
   always_comb begin
      ratio_ok = 1'b0;
      ratio    = '0;
      for (int k = 0; k <= 32; k++) begin
         if (cfg.stride != 4'd0 && 10'(k) * 10'(cfg.stride) == 10'(cfg.limit)) begin
            ratio_ok = 1'b1;
            ratio    = 6'(k);
         end
      end
   end

   assign steps = 6'(({1'b0, ratio} << 1) + 7'd1);

   always_comb begin
      bad_cfg = !ratio_ok || cfg.limit == 6'd0 ||
                cfg.rows == 6'd0 || 32'(cfg.rows) > ROWS ||
                cfg.cols == 6'd0 || 32'(cfg.cols) > COLS ||
                cfg.channels == 7'd0 || 32'(cfg.channels) > CHANNELS ||
                32'({1'b0, ratio, 1'b1}) > MAX_STEPS;
      read_oob = req_data.row >= 5'(cfg.rows) && cfg.rows < 6'd32 ||
                 req_data.col >= 5'(cfg.cols) && cfg.cols < 6'd32 ||
                 {1'b0, req_data.channel} >= cfg.channels;
      if (mode_type'(req_data.mode) == MODE_LOAD_GRAD) begin
         load_oob = 32'(req_data.row) >= ROWS || 32'(req_data.col) >= COLS ||
                    32'(req_data.disp_index) >= Slots;
      end else begin
         load_oob = 32'(req_data.row) >= ROWS || 32'(req_data.col) >= COLS ||
                    32'(req_data.channel) >= CHANNELS;
      end
   end

   // Classify the request.
   always_comb begin
      cmd              = '0;
      cmd.req          = req_data;
      cmd.steps        = steps;
      cmd.early_status = ST_STORED;
      if (mode_type'(req_data.mode) == MODE_READ) begin
         if (bad_cfg) begin
            cmd.early_status = ST_BAD_CFG;
         end else if (read_oob) begin
            cmd.early_status = ST_RANGE;
         end else begin
            cmd.is_read = 1'b1;
         end
      end else if (load_oob) begin
         cmd.early_status = ST_RANGE;
      end else begin
         cmd.is_load = 1'b1;
      end
   end

   assign busy   = q_full;
   assign q_push = start && !q_full;
   assign q_cmd  = cmd;

endmodule

// ===== sv/clb_queue.sv =====
module clb_queue
   import clb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   // Two-entry queue between front end and engine.
   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = 2'(count_ff + 2'(push) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count invalid");

endmodule

// ===== sv/clb_engine.sv =====
module clb_engine
   import clb_pkg::*;
#(
   parameter int ROWS      = RowsDefault,
   parameter int COLS      = ColsDefault,
   parameter int CHANNELS  = ChannelsDefault,
   parameter int MAX_STEPS = MaxStepsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int Slots = MAX_STEPS * MAX_STEPS;
   localparam int RowW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ColW  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ChW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SlotW = $clog2(Slots);
   localparam int StepW = $clog2(MAX_STEPS + 1);
   localparam int GDepth = ROWS * COLS * Slots;
   localparam int FDepth = ROWS * COLS * CHANNELS;
   localparam int GAddrW = $clog2(GDepth);
   localparam int FAddrW = (FDepth > 1) ? $clog2(FDepth) : 1;

   // Feature and gradient memories.
   logic signed [15:0] grad_mem [GDepth];
   logic signed [15:0] a_mem    [FDepth];
   logic signed [15:0] b_mem    [FDepth];

   be_state_type state_ff, state_in;

   logic [StepW-1:0]  sr_ff, sr_in, sc_ff, sc_in;
   logic [SlotW-1:0]  l_ff, l_in;
   logic signed [7:0] dr_ff, dr_in, dc_ff, dc_in;
   logic signed [47:0] acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [1:0]        pend_ff, pend_in;
   logic              pv_a_ff, pv_b_ff;

   logic signed [15:0] g_f_ff, b_f_ff, g_b_ff, a_b_ff;
   logic signed [31:0] prod_a_ff, prod_b_ff;
   logic               pa_ff, pb_ff;

   logic [5:0]  div_cnt_ff, div_cnt_in;
   logic [47:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [7:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic        na_ff, na_in, nb_ff, nb_in;

   rsp_type out_ff, out_in;
   logic    out_v_ff, out_v_in;

   logic signed [8:0] fr, fc, br, bc;
   logic fwd_ok, bwd_ok, issue;
   logic [GAddrW-1:0] g_waddr, g_faddr, g_baddr;
   logic [FAddrW-1:0] f_waddr, f_faddr, f_baddr;
   logic [7:0] ra_sh, rb_sh;

   cmd_type cmd;
   assign cmd = q_head;

   // Neighbor positions for the current displacement.
   always_comb begin
      fr = 9'(signed'({4'b0, cmd.req.row})) + 9'(dr_ff);
      fc = 9'(signed'({4'b0, cmd.req.col})) + 9'(dc_ff);
      br = 9'(signed'({4'b0, cmd.req.row})) - 9'(dr_ff);
      bc = 9'(signed'({4'b0, cmd.req.col})) - 9'(dc_ff);
      fwd_ok = fr >= 0 && fr < 9'(cfg.rows) && fc >= 0 && fc < 9'(cfg.cols);
      bwd_ok = br >= 0 && br < 9'(cfg.rows) && bc >= 0 && bc < 9'(cfg.cols);
      issue  = state_ff == BE_ISSUE;
      g_waddr = GAddrW'((32'(cmd.req.row) * COLS + 32'(cmd.req.col)) * Slots
                + 32'(cmd.req.disp_index));
      f_waddr = FAddrW'((32'(cmd.req.row) * COLS + 32'(cmd.req.col)) * CHANNELS
                + 32'(cmd.req.channel));
      g_faddr = GAddrW'((32'(cmd.req.row) * COLS + 32'(cmd.req.col)) * Slots + 32'(l_ff));
      f_faddr = FAddrW'((32'(fr[RowW-1:0]) * COLS + 32'(fc[ColW-1:0])) * CHANNELS
                + 32'(cmd.req.channel[ChW-1:0]));
      g_baddr = GAddrW'((32'(br[RowW-1:0]) * COLS + 32'(bc[ColW-1:0])) * Slots + 32'(l_ff));
      f_baddr = FAddrW'((32'(br[RowW-1:0]) * COLS + 32'(bc[ColW-1:0])) * CHANNELS
                + 32'(cmd.req.channel[ChW-1:0]));
   end

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (state_ff == BE_IDLE && q_valid && cmd.is_load) begin
         unique case (mode_type'(cmd.req.mode))
            MODE_LOAD_GRAD: grad_mem[g_waddr] <= cmd.req.sample;
            MODE_LOAD_A:    a_mem[f_waddr] <= cmd.req.sample;
            MODE_LOAD_B:    b_mem[f_waddr] <= cmd.req.sample;
            default: ;
         endcase
      end
      g_f_ff <= grad_mem[g_faddr];
      b_f_ff <= b_mem[f_faddr];
      g_b_ff <= grad_mem[g_baddr];
      a_b_ff <= a_mem[f_baddr];
      prod_a_ff <= g_f_ff * b_f_ff;
      prod_b_ff <= g_b_ff * a_b_ff;
   end

   // Valid pipeline alongside the memory reads and products.
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_a_ff <= 1'b0;
         pv_b_ff <= 1'b0;
         pa_ff   <= 1'b0;
         pb_ff   <= 1'b0;
      end else begin
         pv_a_ff <= issue && fwd_ok;
         pv_b_ff <= issue && bwd_ok;
         pa_ff   <= pv_a_ff;
         pb_ff   <= pv_b_ff;
      end
   end

   // Shift-subtract step of the magnitude division.
   always_comb begin
      ra_sh = {ra_ff[6:0], qa_ff[47]};
      rb_sh = {rb_ff[6:0], qb_ff[47]};
   end

   // Engine sequencer.
   always_comb begin
      state_in   = state_ff;
      sr_in      = sr_ff;
      sc_in      = sc_ff;
      l_in       = l_ff;
      dr_in      = dr_ff;
      dc_in      = dc_ff;
      acc_a_in   = acc_a_ff + (pa_ff ? 48'(prod_a_ff) : 48'sd0);
      acc_b_in   = acc_b_ff + (pb_ff ? 48'(prod_b_ff) : 48'sd0);
      pend_in    = pend_ff;
      div_cnt_in = div_cnt_ff;
      qa_in      = qa_ff;
      qb_in      = qb_ff;
      ra_in      = ra_ff;
      rb_in      = rb_ff;
      na_in      = na_ff;
      nb_in      = nb_ff;
      out_in     = out_ff;
      out_v_in   = 1'b0;
      q_pop      = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            if (q_valid) begin
               if (cmd.is_read) begin
                  state_in = BE_ISSUE;
                  sr_in    = '0;
                  sc_in    = '0;
                  l_in     = '0;
                  dr_in    = -8'(signed'({2'b0, cfg.limit}));
                  dc_in    = -8'(signed'({2'b0, cfg.limit}));
                  acc_a_in = '0;
                  acc_b_in = '0;
               end else begin
                  q_pop    = 1'b1;
                  out_in   = '{grad_a_value: '0, grad_b_value: '0,
                               status: cmd.early_status};
                  out_v_in = 1'b1;
               end
            end
         end
         BE_ISSUE: begin
            l_in = SlotW'(l_ff + 1'b1);
            if (6'(sc_ff) == cmd.steps - 6'd1) begin
               sc_in = '0;
               dc_in = -8'(signed'({2'b0, cfg.limit}));
               dr_in = dr_ff + 8'(cfg.stride);
               sr_in = StepW'(sr_ff + 1'b1);
               if (6'(sr_ff) == cmd.steps - 6'd1) begin
                  state_in = BE_WAIT;
                  pend_in  = 2'd3;
               end
            end else begin
               sc_in = StepW'(sc_ff + 1'b1);
               dc_in = dc_ff + 8'(cfg.stride);
            end
         end
         BE_WAIT: begin
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               state_in = BE_DRAIN;
            end
         end
         BE_DRAIN: begin
            na_in = acc_a_ff[47];
            nb_in = acc_b_ff[47];
            qa_in = acc_a_ff[47] ? 48'(-acc_a_ff) : 48'(acc_a_ff);
            qb_in = acc_b_ff[47] ? 48'(-acc_b_ff) : 48'(acc_b_ff);
            ra_in = '0;
            rb_in = '0;
            div_cnt_in = 6'd0;
            state_in = BE_DIV;
         end
         BE_DIV: begin
            if (ra_sh >= {1'b0, cfg.channels}) begin
               ra_in = ra_sh - {1'b0, cfg.channels};
               qa_in = {qa_ff[46:0], 1'b1};
            end else begin
               ra_in = ra_sh;
               qa_in = {qa_ff[46:0], 1'b0};
            end
            if (rb_sh >= {1'b0, cfg.channels}) begin
               rb_in = rb_sh - {1'b0, cfg.channels};
               qb_in = {qb_ff[46:0], 1'b1};
            end else begin
               rb_in = rb_sh;
               qb_in = {qb_ff[46:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd47) begin
               state_in = BE_DONE;
            end
         end
         BE_DONE: begin
            q_pop    = 1'b1;
            out_in   = '{grad_a_value: 40'(na_ff ? -qa_ff : qa_ff),
                         grad_b_value: 40'(nb_ff ? -qb_ff : qb_ff),
                         status: ST_READ_OK};
            out_v_in = 1'b1;
            state_in = BE_IDLE;
         end
         default: state_in = BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
      end
      sr_ff      <= sr_in;
      sc_ff      <= sc_in;
      l_ff       <= l_in;
      dr_ff      <= dr_in;
      dc_ff      <= dc_in;
      acc_a_ff   <= acc_a_in;
      acc_b_ff   <= acc_b_in;
      pend_ff    <= pend_in;
      div_cnt_ff <= div_cnt_in;
      qa_ff      <= qa_in;
      qb_ff      <= qb_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid) else $error("pop without response");
   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(q_pop)) else $error("response without pop");
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

// ===== sv/correlation_layer_backward_top.sv =====
// Load requests: response registered via the queue slot and the output register, one request
// per cycle sustained while no read holds the engine. Read requests: response time is set by the
// one-displacement-per-cycle walk over the memory read ports and a 48-step divider.
// A two-entry queue decouples acceptance; busy rises only when it is full.
// Responses cannot be stalled. Synchronous active-high reset clears control and
// restores the register defaults; memory contents are undefined until written.
module correlation_layer_backward_top
   import clb_pkg::*;
#(
   parameter int ROWS      = RowsDefault,
   parameter int COLS      = ColsDefault,
   parameter int CHANNELS  = ChannelsDefault,
   parameter int MAX_STEPS = MaxStepsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_pop, q_full, q_valid;
   cmd_type q_cmd, q_head;

   // Configuration register file.
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS:     cfg_in.rows     = csr_wdata[5:0];
            CSR_COLS:     cfg_in.cols     = csr_wdata[5:0];
            CSR_CHANNELS: cfg_in.channels = csr_wdata[6:0];
            CSR_STRIDE:   cfg_in.stride   = csr_wdata[3:0];
            CSR_LIMIT:    cfg_in.limit    = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rows: 6'd32, cols: 6'd32, channels: 7'd64, stride: 4'd2,
                     limit: 6'd8};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clb_front #(.ROWS(ROWS), .COLS(COLS), .CHANNELS(CHANNELS), .MAX_STEPS(MAX_STEPS))
   u_front (
      .start(start), .req_data(req_data),
      .cfg(cfg_ff), .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd), .busy(busy)
   );

   clb_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_cmd),
      .pop(q_pop), .full(q_full), .not_empty(q_valid), .head(q_head)
   );

   clb_engine #(.ROWS(ROWS), .COLS(COLS), .CHANNELS(CHANNELS), .MAX_STEPS(MAX_STEPS))
   u_engine (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid),
      .q_head(q_head), .q_pop(q_pop), .rsp_valid(rsp_strobe), .rsp_data(rsp_data)
   );

endmodule
